### rtl/core/sas_pkg.sv
// package for the sprite animation sequencer: widths, codes, states
package sas_pkg;

	localparam int PATTERN_SLOTS_DEF = 128;
	localparam int PLAYER_SLOTS_DEF  = 256;

	localparam logic [25:0] ACC_MAX   = 26'h3FFFFFF;
	localparam logic [15:0] COORD_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		KIND_REGISTER = 3'd0,
		KIND_CREATE   = 3'd1,
		KIND_DESTROY  = 3'd2,
		KIND_TICK     = 3'd3,
		KIND_QUERY    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_SLOT = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PSCAN,
		S_CREATE_RD,
		S_USCAN,
		S_TICK_RD,
		S_TICK_PAT,
		S_TICK_ADV,
		S_TICK_WR,
		S_Q_RD,
		S_Q_PAT,
		S_Q_INIT,
		S_Q_DIV,
		S_Q_MULX,
		S_Q_MULY,
		S_Q_SUMY,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  player_index;
		logic [6:0]  pattern_index;
		logic [15:0] texture_id;
		logic [9:0]  frame_count;
		logic [9:0]  columns;
		logic [23:0] time_amount;
		logic [11:0] cell_width;
		logic [11:0] cell_height;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic        looping;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  new_index;
		logic [15:0] texture_out;
		logic [9:0]  frame_number;
		logic [15:0] source_x;
		logic [15:0] source_y;
		logic [11:0] source_width;
		logic [11:0] source_height;
	} rsp_t;

	typedef struct packed {
		logic [23:0] period;
		logic [9:0]  frames;
		logic [9:0]  cols;
		logic        loop;
		logic [15:0] tex;
	} timing_t;

	typedef struct packed {
		logic [11:0] cw;
		logic [11:0] ch;
		logic [11:0] ox;
		logic [11:0] oy;
	} shape_t;

	typedef struct packed {
		logic [6:0]  pat;
		logic [9:0]  frame;
		logic [25:0] acc;
	} player_t;

endpackage

### rtl/core/sas_stream_if.sv
// valid/ready channel carrying one payload
interface sas_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/sprite_animation_sequencer.sv
// sprite animation sequencer top level: command sequencer over pattern and player tables
//
//  channel  dir  payload        beat
//  cmd      in   sas_pkg::cmd_t one command
//  rsp      out  sas_pkg::rsp_t one result per command
//
// one command at a time; cmd.ready is low from acceptance until the result is taken
// tick: read, pattern, advance and write states for each player slot in use; unused slots are skipped
// register: scans pattern slots for a free one, up to PATTERN_SLOTS
// create: pattern check, then free-slot scan over up to PLAYER_SLOTS slots
// query: restoring divider shared for frame div/mod columns
// reset clears valid and in-use flags at once; result holds until rsp.ready
module sprite_animation_sequencer #(
	parameter int PATTERN_SLOTS = sas_pkg::PATTERN_SLOTS_DEF,
	parameter int PLAYER_SLOTS  = sas_pkg::PLAYER_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	sas_stream_if.sink   cmd,
	sas_stream_if.source rsp
);
	localparam int PAW = PATTERN_SLOTS > 1 ? $clog2(PATTERN_SLOTS) : 1;
	localparam int PLW = PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1;
	localparam int IW  = (PAW > PLW ? PAW : PLW) + 1;

	sas_pkg::state_t state_q, state_d;
	sas_pkg::cmd_t   cmd_q;
	sas_pkg::rsp_t   rsp_q;
	sas_pkg::rsp_t   rsp_init;

	logic [PATTERN_SLOTS-1:0] pvalid_q;
	logic [PLAYER_SLOTS-1:0]  inuse_q;

	sas_pkg::timing_t timing_mem [PATTERN_SLOTS];
	sas_pkg::shape_t  shape_mem [PATTERN_SLOTS];
	sas_pkg::player_t player_mem [PLAYER_SLOTS];

	sas_pkg::timing_t timing_rd_q;
	sas_pkg::shape_t  shape_rd_q;
	sas_pkg::player_t player_rd_q;
	sas_pkg::player_t adv_q, adv_d;

	logic [IW-1:0] idx_q;
	logic [PAW-1:0] paddr;
	logic [PLW-1:0] uaddr;
	sas_pkg::player_t pwr_data;
	logic pwr_en, twr_en;

	logic [9:0]  rem_q, quo_q, div_q;
	logic [3:0]  bit_q;
	logic [27:0] prod_q;

	assign uaddr = idx_q[PLW-1:0];

	always_ff @(posedge clk) begin
		if (twr_en) begin
			timing_mem[paddr] <= '{cmd_q.time_amount, cmd_q.frame_count, cmd_q.columns,
				cmd_q.looping, cmd_q.texture_id};
			shape_mem[paddr] <= '{cmd_q.cell_width, cmd_q.cell_height, cmd_q.origin_x,
				cmd_q.origin_y};
		end
		timing_rd_q <= timing_mem[paddr];
		shape_rd_q  <= shape_mem[paddr];
	end

	always_ff @(posedge clk) begin
		if (pwr_en) begin
			player_mem[uaddr] <= pwr_data;
		end
		player_rd_q <= player_mem[uaddr];
	end

	// pattern address: scan index on register, command's pattern on create, player's pattern otherwise
	always_comb begin
		case (state_q)
			sas_pkg::S_PSCAN: paddr = idx_q[PAW-1:0];
			sas_pkg::S_CREATE_RD: paddr = PAW'(cmd_q.pattern_index);
			default: paddr = PAW'(player_rd_q.pat);
		endcase
	end

	logic        pat_ok;
	logic        pl_in_range;
	logic        q_ok;
	logic [9:0]  nxt_frame;
	logic [25:0] acc_sub;
	logic [26:0] acc_sum;
	logic [10:0] trial;
	logic [16:0] sx;
	logic [16:0] sy;

	always_comb begin
		pat_ok = (32'(cmd_q.pattern_index) < PATTERN_SLOTS) &&
			pvalid_q[PAW'(cmd_q.pattern_index)];
		pl_in_range = 32'(cmd.payload.player_index) < PLAYER_SLOTS;
		q_ok = pl_in_range && inuse_q[PLW'(cmd.payload.player_index)];
		rsp_init = '0;
		if ((cmd.payload.kind == sas_pkg::KIND_DESTROY && !pl_in_range) ||
			(cmd.payload.kind == sas_pkg::KIND_QUERY && !q_ok))
			rsp_init.status = sas_pkg::ST_BAD;
		if (11'(player_rd_q.frame) + 11'd1 >= 11'(timing_rd_q.frames)) begin
			nxt_frame = (timing_rd_q.loop || timing_rd_q.frames == 10'd0) ? 10'd0 :
				timing_rd_q.frames - 10'd1;
		end else begin
			nxt_frame = player_rd_q.frame + 10'd1;
		end
		acc_sub = player_rd_q.acc - 26'(timing_rd_q.period);
		adv_d = player_rd_q;
		if (player_rd_q.acc >= 26'(timing_rd_q.period)) begin
			adv_d.frame = nxt_frame;
			adv_d.acc   = acc_sub;
		end
		acc_sum = 27'(adv_q.acc) + 27'(cmd_q.time_amount);
		trial = {rem_q, quo_q[9]} - {1'b0, div_q};
		sx = 17'(shape_rd_q.ox) + 17'(prod_q[15:0]);
		sy = 17'(shape_rd_q.oy) + 17'(prod_q[15:0]);
	end

	always_comb begin
		state_d  = state_q;
		pwr_en   = 1'b0;
		twr_en   = 1'b0;
		pwr_data = player_rd_q;
		case (state_q)
			sas_pkg::S_IDLE: begin
				if (cmd.valid) begin
					case (cmd.payload.kind)
						sas_pkg::KIND_REGISTER: state_d = sas_pkg::S_PSCAN;
						sas_pkg::KIND_CREATE:   state_d = sas_pkg::S_CREATE_RD;
						sas_pkg::KIND_TICK:     state_d = sas_pkg::S_TICK_RD;
						sas_pkg::KIND_QUERY:    state_d = q_ok ? sas_pkg::S_Q_RD : sas_pkg::S_OUT;
						default:                state_d = sas_pkg::S_OUT;
					endcase
				end
			end
			sas_pkg::S_PSCAN: begin
				if (!pvalid_q[idx_q[PAW-1:0]]) begin
					twr_en  = 1'b1;
					state_d = sas_pkg::S_OUT;
				end else if (32'(idx_q) == PATTERN_SLOTS - 1) begin
					state_d = sas_pkg::S_OUT;
				end
			end
			sas_pkg::S_CREATE_RD: state_d = pat_ok ? sas_pkg::S_USCAN : sas_pkg::S_OUT;
			sas_pkg::S_USCAN: begin
				if (!inuse_q[uaddr]) begin
					pwr_en   = 1'b1;
					pwr_data = '{7'(cmd_q.pattern_index), 10'd0, 26'd0};
					state_d  = sas_pkg::S_OUT;
				end else if (32'(idx_q) == PLAYER_SLOTS - 1) begin
					state_d = sas_pkg::S_OUT;
				end
			end
			sas_pkg::S_TICK_RD: begin
				if (32'(idx_q) >= PLAYER_SLOTS) begin
					state_d = sas_pkg::S_OUT;
				end else if (inuse_q[uaddr]) begin
					state_d = sas_pkg::S_TICK_PAT;
				end
			end
			sas_pkg::S_TICK_PAT: state_d = sas_pkg::S_TICK_ADV;
			sas_pkg::S_TICK_ADV: state_d = sas_pkg::S_TICK_WR;
			sas_pkg::S_TICK_WR: begin
				pwr_en = 1'b1;
				pwr_data = adv_q;
				pwr_data.acc = acc_sum[26] ? sas_pkg::ACC_MAX : acc_sum[25:0];
				state_d = sas_pkg::S_TICK_RD;
			end
			sas_pkg::S_Q_RD: state_d = sas_pkg::S_Q_PAT;
			sas_pkg::S_Q_PAT: state_d = sas_pkg::S_Q_INIT;
			sas_pkg::S_Q_INIT: state_d = sas_pkg::S_Q_DIV;
			sas_pkg::S_Q_DIV: if (bit_q == 4'd9) state_d = sas_pkg::S_Q_MULX;
			sas_pkg::S_Q_MULX: state_d = sas_pkg::S_Q_MULY;
			sas_pkg::S_Q_MULY: state_d = sas_pkg::S_Q_SUMY;
			sas_pkg::S_Q_SUMY: state_d = sas_pkg::S_OUT;
			sas_pkg::S_OUT: if (rsp.ready) state_d = sas_pkg::S_IDLE;
			default: state_d = sas_pkg::S_IDLE;
		endcase
	end

	assign cmd.ready   = (state_q == sas_pkg::S_IDLE);
	assign rsp.valid   = (state_q == sas_pkg::S_OUT);
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sas_pkg::S_IDLE;
			pvalid_q <= '0;
			inuse_q  <= '0;
		end else begin
			state_q <= state_d;
			if (twr_en) pvalid_q[paddr] <= 1'b1;
			if (state_q == sas_pkg::S_USCAN && !inuse_q[uaddr]) inuse_q[uaddr] <= 1'b1;
			if (cmd.valid && cmd.ready && cmd.payload.kind == sas_pkg::KIND_DESTROY &&
				pl_in_range)
				inuse_q[PLW'(cmd.payload.player_index)] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.payload;
			rsp_q <= rsp_init;
			idx_q <= (cmd.payload.kind == sas_pkg::KIND_QUERY) ?
				IW'(cmd.payload.player_index) : '0;
		end else begin
			case (state_q)
				sas_pkg::S_PSCAN: begin
					if (!pvalid_q[idx_q[PAW-1:0]]) rsp_q.new_index <= 8'(idx_q);
					else if (32'(idx_q) == PATTERN_SLOTS - 1) rsp_q.status <= sas_pkg::ST_NO_SLOT;
					idx_q <= idx_q + IW'(1);
				end
				sas_pkg::S_CREATE_RD: if (!pat_ok) rsp_q.status <= sas_pkg::ST_BAD;
				sas_pkg::S_USCAN: begin
					if (!inuse_q[uaddr]) rsp_q.new_index <= 8'(idx_q);
					else if (32'(idx_q) == PLAYER_SLOTS - 1) rsp_q.status <= sas_pkg::ST_NO_SLOT;
					idx_q <= idx_q + IW'(1);
				end
				sas_pkg::S_TICK_RD: if (!inuse_q[uaddr] && 32'(idx_q) < PLAYER_SLOTS)
					idx_q <= idx_q + IW'(1);
				sas_pkg::S_TICK_ADV: adv_q <= adv_d;
				sas_pkg::S_TICK_WR: idx_q <= idx_q + IW'(1);
				sas_pkg::S_Q_INIT: begin
					div_q <= timing_rd_q.cols == 10'd0 ? 10'd1 : timing_rd_q.cols;
					rem_q <= '0;
					quo_q <= player_rd_q.frame;
					bit_q <= '0;
					rsp_q.texture_out   <= timing_rd_q.tex;
					rsp_q.frame_number  <= player_rd_q.frame;
					rsp_q.source_width  <= shape_rd_q.cw;
					rsp_q.source_height <= shape_rd_q.ch;
				end
				sas_pkg::S_Q_DIV: begin
					if (!trial[10]) begin
						rem_q <= trial[9:0];
						quo_q <= {quo_q[8:0], 1'b1};
					end else begin
						rem_q <= {rem_q[8:0], quo_q[9]};
						quo_q <= {quo_q[8:0], 1'b0};
					end
					bit_q <= bit_q + 4'd1;
				end
				sas_pkg::S_Q_MULX: prod_q <= 28'(shape_rd_q.cw) * 28'(rem_q);
				sas_pkg::S_Q_MULY: begin
					rsp_q.source_x <= (prod_q[27:16] != '0 || sx[16]) ? sas_pkg::COORD_MAX :
						sx[15:0];
					prod_q <= 28'(shape_rd_q.ch) * 28'(quo_q);
				end
				sas_pkg::S_Q_SUMY:
					rsp_q.source_y <= (prod_q[27:16] != '0 || sy[16]) ? sas_pkg::COORD_MAX :
						sy[15:0];
				default: ;
			endcase
		end
	end
endmodule
